>>> rtl/dataflow_depth_tracker_macros.svh
// Assertion macros used by the checker file of the dependence tracker.
// Depends on nothing; include by bare file name.
`ifndef DATAFLOW_DEPTH_TRACKER_MACROS_SVH
`define DATAFLOW_DEPTH_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define DDT_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dependence tracker assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define DDT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dependence tracker assertion failed");

`endif

>>> rtl/ddt_pkg.sv
// Shared constants and types for the dataflow depth tracker.
// Depends on nothing; imported by every tracker module.
package ddt_pkg;

  // Field widths
  localparam int unsigned RegIdxW    = 5;
  localparam int unsigned NumRegs    = 1 << RegIdxW;
  localparam int unsigned OpcodeW    = 4;
  localparam int unsigned NumOpcodes = 1 << OpcodeW;
  localparam int unsigned LatW       = 8;
  localparam int unsigned InstIdxW   = 16;
  localparam int unsigned DepIdxW    = InstIdxW + 1;
  localparam int unsigned InstCntW   = InstIdxW + 1;
  localparam int unsigned DepthW     = 24;

  // Trace length limit and saturation value
  localparam logic [InstCntW-1:0]       MaxInsts = {1'b1, {InstIdxW{1'b0}}};
  localparam logic [DepthW-1:0]         DepthMax = '1;
  localparam logic signed [DepIdxW-1:0] EntryIdx = '1;

  typedef enum logic {
    CmdLoad = 1'b0,
    CmdInst = 1'b1
  } cmd_e;

  // One register's dependence record
  typedef struct packed {
    logic signed [DepIdxW-1:0] writer;
    logic [DepthW-1:0]         finish;
  } dep_entry_t;

  localparam dep_entry_t DepEntryReset = '{writer: EntryIdx, finish: '0};

  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] addr1;
    logic [RegIdxW-1:0] addr2;
  } dep_rd_t;

  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] addr;
    dep_entry_t         data;
  } dep_wr_t;

endpackage

>>> rtl/ddt_lat_table.sv
// Opcode latency table: written by load transfers, read combinationally.
// Depends on ddt_pkg.
module ddt_lat_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [ddt_pkg::OpcodeW-1:0]  wr_opcode_i,
  input  logic [ddt_pkg::LatW-1:0]     wr_latency_i,
  input  logic [ddt_pkg::OpcodeW-1:0]  rd_opcode_i,
  output logic [ddt_pkg::LatW-1:0]     rd_latency_o
);
  import ddt_pkg::*;

  logic [LatW-1:0] lat_q [NumOpcodes];

  // Write one entry per load, clear all on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumOpcodes; i++) begin
        lat_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      lat_q[wr_opcode_i] <= wr_latency_i;
    end
  end

  assign rd_latency_o = lat_q[rd_opcode_i];

endmodule

>>> rtl/ddt_dep_table.sv
// Per-register dependence memory (last writer, finish time) with valid bits,
// two registered read ports and write-first bypass. Depends on ddt_pkg.
module ddt_dep_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ddt_pkg::dep_rd_t    rd_i,
  input  ddt_pkg::dep_wr_t    wr_i,
  output ddt_pkg::dep_entry_t rd1_o,
  output ddt_pkg::dep_entry_t rd2_o
);
  import ddt_pkg::*;

  dep_entry_t         mem_q [NumRegs];
  logic [NumRegs-1:0] vld_q;
  dep_entry_t         rd1_q, rd2_q;
  logic               rd1_vld_q, rd2_vld_q, rd1_vld_d, rd2_vld_d;
  logic               hit1, hit2;

  // Forward a write landing in the same cycle as the read
  assign hit1 = wr_i.en && (wr_i.addr == rd_i.addr1);
  assign hit2 = wr_i.en && (wr_i.addr == rd_i.addr2);

  always_comb begin
    rd1_vld_d = hit1 | vld_q[rd_i.addr1];
    rd2_vld_d = hit2 | vld_q[rd_i.addr2];
  end

  // Memory array write
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read data, write-first on an address match
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd1_q <= hit1 ? wr_i.data : mem_q[rd_i.addr1];
      rd2_q <= hit2 ? wr_i.data : mem_q[rd_i.addr2];
    end
  end

  // Valid bits: an unwritten register reads as the program entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd1_vld_q <= 1'b0;
      rd2_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rd1_vld_q <= rd1_vld_d;
        rd2_vld_q <= rd2_vld_d;
      end
    end
  end

  assign rd1_o = rd1_vld_q ? rd1_q : DepEntryReset;
  assign rd2_o = rd2_vld_q ? rd2_q : DepEntryReset;

endmodule

>>> rtl/dataflow_depth_tracker.sv
// Dataflow depth tracker: register dependence scoreboard over an instruction
// trace. Takes one transfer per cycle while the input side does not stall; a
// result passes through the input register, then the result register. Source
// records are read from the dependence memory as the transfer is taken, with
// a bypass from the write of the instruction ahead, so back-to-back dependent
// instructions see each other. Load transfers and instructions beyond the
// trace limit of 65536 give no result. The input side stalls only while the
// result register is full and its consumer stalls.
module dataflow_depth_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_i,
  input  logic [ddt_pkg::OpcodeW-1:0]         opcode_i,
  input  logic [ddt_pkg::LatW-1:0]            latency_value_i,
  input  logic [ddt_pkg::RegIdxW-1:0]         src1_reg_i,
  input  logic [ddt_pkg::RegIdxW-1:0]         src2_reg_i,
  input  logic [ddt_pkg::RegIdxW-1:0]         dst_reg_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ddt_pkg::InstIdxW-1:0]        inst_index_o,
  output logic signed [ddt_pkg::DepIdxW-1:0]  dep1_index_o,
  output logic signed [ddt_pkg::DepIdxW-1:0]  dep2_index_o,
  output logic [ddt_pkg::DepthW-1:0]          start_depth_o,
  output logic [ddt_pkg::DepthW-1:0]          program_depth_o
);
  import ddt_pkg::*;

  // Input register
  logic               s_valid_q, s_valid_d;
  cmd_e               s_cmd_q;
  logic [OpcodeW-1:0] s_opcode_q;
  logic [LatW-1:0]    s_lat_q;
  logic [RegIdxW-1:0] s_dst_q;

  // Running state
  logic [InstCntW-1:0] cnt_q;
  logic [DepthW-1:0]   max_q;

  // Result register
  logic                      out_valid_q, out_valid_d;
  logic [InstIdxW-1:0]       out_idx_q;
  logic signed [DepIdxW-1:0] out_dep1_q, out_dep2_q;
  logic [DepthW-1:0]         out_start_q, out_prog_q;

  logic                accept_in, out_free, adv, is_inst, do_inst, do_load;
  logic [LatW-1:0]     lat;
  dep_entry_t          src1, src2;
  dep_rd_t             dep_rd;
  dep_wr_t             dep_wr;
  logic [DepthW-1:0]   start_depth, fin, max_d;
  logic [DepthW:0]     fin_sum;

  // Handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = s_valid_q && out_free;
  assign in_stall_o = s_valid_q && !out_free;
  assign accept_in  = in_valid_i && !in_stall_o;

  assign is_inst = (s_cmd_q == CmdInst);
  assign do_inst = adv && is_inst && (cnt_q < MaxInsts);
  assign do_load = adv && !is_inst;

  // Capture the incoming transfer
  always_comb begin
    s_valid_d = s_valid_q;
    if (accept_in) begin
      s_valid_d = 1'b1;
    end else if (adv) begin
      s_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= s_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      s_cmd_q    <= cmd_e'(cmd_i);
      s_opcode_q <= opcode_i;
      s_lat_q    <= latency_value_i;
      s_dst_q    <= dst_reg_i;
    end
  end

  // Tables
  ddt_lat_table u_lat_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (do_load),
    .wr_opcode_i  (s_opcode_q),
    .wr_latency_i (s_lat_q),
    .rd_opcode_i  (s_opcode_q),
    .rd_latency_o (lat)
  );

  assign dep_rd = '{en: accept_in, addr1: src1_reg_i, addr2: src2_reg_i};

  ddt_dep_table u_dep_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (dep_rd),
    .wr_i   (dep_wr),
    .rd1_o  (src1),
    .rd2_o  (src2)
  );

  // Start depth, saturating finish time and program depth
  always_comb begin
    start_depth = (src1.finish > src2.finish) ? src1.finish : src2.finish;
    fin_sum     = {1'b0, start_depth} + {{(DepthW + 1 - LatW){1'b0}}, lat};
    fin         = fin_sum[DepthW] ? DepthMax : fin_sum[DepthW-1:0];
    max_d       = (fin > max_q) ? fin : max_q;
  end

  // Record this instruction as the destination's last writer
  always_comb begin
    dep_wr.en          = do_inst;
    dep_wr.addr        = s_dst_q;
    dep_wr.data.writer = signed'({1'b0, cnt_q[InstIdxW-1:0]});
    dep_wr.data.finish = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      max_q <= '0;
    end else if (do_inst) begin
      cnt_q <= cnt_q + InstCntW'(1);
      max_q <= max_d;
    end
  end

  // Result register: load on a live instruction, drop once transferred
  always_comb begin
    out_valid_d = out_valid_q;
    if (do_inst) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_inst) begin
      out_idx_q   <= cnt_q[InstIdxW-1:0];
      out_dep1_q  <= src1.writer;
      out_dep2_q  <= src2.writer;
      out_start_q <= start_depth;
      out_prog_q  <= max_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign inst_index_o    = out_idx_q;
  assign dep1_index_o    = out_dep1_q;
  assign dep2_index_o    = out_dep2_q;
  assign start_depth_o   = out_start_q;
  assign program_depth_o = out_prog_q;

endmodule

>>> rtl/ddt_checker.sv
// Port-level checks for the dataflow depth tracker, bound to the top level.
// Depends on ddt_pkg and dataflow_depth_tracker_macros.svh.
`include "dataflow_depth_tracker_macros.svh"

module ddt_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [ddt_pkg::InstIdxW-1:0]        inst_index_o,
  input logic signed [ddt_pkg::DepIdxW-1:0]  dep1_index_o,
  input logic signed [ddt_pkg::DepIdxW-1:0]  dep2_index_o,
  input logic [ddt_pkg::DepthW-1:0]          start_depth_o,
  input logic [ddt_pkg::DepthW-1:0]          program_depth_o
);
  import ddt_pkg::*;

  logic                      out_hold;
  logic signed [DepIdxW-1:0] cur_idx;
  logic                      deps_older;

  assign out_hold   = out_valid_o && out_stall_i;
  assign cur_idx    = signed'({1'b0, inst_index_o});
  assign deps_older = (dep1_index_o < cur_idx) && (dep2_index_o < cur_idx);

  // Hold a stalled result and its index and program depth
  `DDT_ASSERT_NEXT(a_out_valid_held, clk_i, rst_ni, out_hold, out_valid_o)
  `DDT_ASSERT_NEXT(a_out_data_held, clk_i, rst_ni, out_hold, $stable(inst_index_o) && $stable(program_depth_o))

  // Stall the input only behind a full, stalled result register
  `DDT_ASSERT_NOW(a_in_stall_cause, clk_i, rst_ni, in_stall_o, out_hold)

  // Dependences point to the entry or to earlier instructions
  `DDT_ASSERT_NOW(a_deps_older, clk_i, rst_ni, out_valid_o, deps_older)

  // Program depth covers this instruction's start depth
  `DDT_ASSERT_NOW(a_depth_order, clk_i, rst_ni, out_valid_o, program_depth_o >= start_depth_o)

endmodule

bind dataflow_depth_tracker ddt_checker u_ddt_checker (.*);

>>> tb/tb_dataflow_depth_tracker.sv
// Self-checking testbench for the dataflow depth tracker: streams load and instruction
// transfers, predicts every dependence report and compares each one field by field.
// Depends on ddt_pkg and the dataflow_depth_tracker RTL only.
module tb_dataflow_depth_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import ddt_pkg::*;

  localparam int StallLimit = 2000;
  localparam int RandomItems = 1150;
  localparam int TailCycles = 20;

  typedef struct {
    cmd_e               cmd;
    logic [OpcodeW-1:0] opcode;
    logic [LatW-1:0]    latency;
    logic [RegIdxW-1:0] src1;
    logic [RegIdxW-1:0] src2;
    logic [RegIdxW-1:0] dst;
  } trace_item_t;

  typedef struct {
    logic [InstIdxW-1:0]        inst_index;
    logic signed [DepIdxW-1:0]  dep1;
    logic signed [DepIdxW-1:0]  dep2;
    logic [DepthW-1:0]          start_depth;
    logic [DepthW-1:0]          program_depth;
  } depth_report_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       cmd_i = 1'b0;
  logic [OpcodeW-1:0]         opcode_i = '0;
  logic [LatW-1:0]            latency_value_i = '0;
  logic [RegIdxW-1:0]         src1_reg_i = '0;
  logic [RegIdxW-1:0]         src2_reg_i = '0;
  logic [RegIdxW-1:0]         dst_reg_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [InstIdxW-1:0]        inst_index_o;
  logic signed [DepIdxW-1:0]  dep1_index_o;
  logic signed [DepIdxW-1:0]  dep2_index_o;
  logic [DepthW-1:0]          start_depth_o;
  logic [DepthW-1:0]          program_depth_o;

  // Stimulus and expected reports
  trace_item_t   trace_items[$];
  depth_report_t due_reports[$];
  trace_item_t   held_item;
  depth_report_t got_report;

  // Predicted tracker state
  logic [LatW-1:0]            lat_tbl[NumOpcodes];
  logic signed [DepIdxW-1:0]  reg_writer[NumRegs];
  logic [DepthW-1:0]          reg_finish[NumRegs];
  logic [InstCntW-1:0]        inst_count;
  logic [DepthW-1:0]          peak_depth;

  int mismatches = 0;
  int idle_cycles = 0;
  int accepted_items = 0;
  int phase1_end = 0;
  int phase2_end = 0;

  dataflow_depth_tracker DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .opcode_i       (opcode_i),
    .latency_value_i(latency_value_i),
    .src1_reg_i     (src1_reg_i),
    .src2_reg_i     (src2_reg_i),
    .dst_reg_i      (dst_reg_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .inst_index_o   (inst_index_o),
    .dep1_index_o   (dep1_index_o),
    .dep2_index_o   (dep2_index_o),
    .start_depth_o  (start_depth_o),
    .program_depth_o(program_depth_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle rates: sender light and receiver heavy, then swapped, then none
  function automatic int send_idle_pct();
    if (accepted_items < phase1_end) return 20;
    if (accepted_items < phase2_end) return 59;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (accepted_items < phase1_end) return 59;
    if (accepted_items < phase2_end) return 20;
    return 0;
  endfunction

  function automatic void queue_load(logic [OpcodeW-1:0] opc, logic [LatW-1:0] lat);
    trace_item_t it;
    it.cmd     = CmdLoad;
    it.opcode  = opc;
    it.latency = lat;
    it.src1    = RegIdxW'($urandom_range(0, NumRegs - 1));
    it.src2    = RegIdxW'($urandom_range(0, NumRegs - 1));
    it.dst     = RegIdxW'($urandom_range(0, NumRegs - 1));
    trace_items.push_back(it);
  endfunction

  function automatic void queue_inst(logic [OpcodeW-1:0] opc, logic [RegIdxW-1:0] s1,
                                     logic [RegIdxW-1:0] s2, logic [RegIdxW-1:0] d);
    trace_item_t it;
    it.cmd     = CmdInst;
    it.opcode  = opc;
    it.latency = LatW'($urandom_range(0, 255));
    it.src1    = s1;
    it.src2    = s2;
    it.dst     = d;
    trace_items.push_back(it);
  endfunction

  // Favour a few hot registers so that dependence chains form
  function automatic logic [RegIdxW-1:0] pick_reg();
    if ($urandom_range(0, 1) != 0) return RegIdxW'($urandom_range(0, 3));
    return RegIdxW'($urandom_range(0, NumRegs - 1));
  endfunction

  function automatic logic [LatW-1:0] pick_latency();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return LatW'($urandom_range(0, 255));
  endfunction

  // Advance the predicted scoreboard by one accepted transfer
  task automatic trace_dataflow(input trace_item_t it);
    logic signed [DepIdxW-1:0] dep_a, dep_b;
    logic [DepthW-1:0]         fin_a, fin_b, start_at;
    logic [DepthW:0]           sum;
    depth_report_t             rep;
    if (it.cmd == CmdLoad) begin
      lat_tbl[it.opcode] = it.latency;
    end else if (inst_count < MaxInsts) begin
      // read both sources before the destination is written
      dep_a = reg_writer[it.src1];
      fin_a = reg_finish[it.src1];
      dep_b = reg_writer[it.src2];
      fin_b = reg_finish[it.src2];
      start_at = (fin_a > fin_b) ? fin_a : fin_b;
      sum = start_at + lat_tbl[it.opcode];
      if (sum > DepthMax) sum = DepthMax;
      if (sum[DepthW-1:0] > peak_depth) peak_depth = sum[DepthW-1:0];
      reg_writer[it.dst] = $signed(inst_count);
      reg_finish[it.dst] = sum[DepthW-1:0];
      rep.inst_index    = inst_count[InstIdxW-1:0];
      rep.dep1          = dep_a;
      rep.dep2          = dep_b;
      rep.start_depth   = start_at;
      rep.program_depth = peak_depth;
      due_reports.push_back(rep);
      inst_count++;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] expv,
                             input logic [31:0] actv);
    if (actv !== expv) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expv, actv);
      mismatches++;
    end
  endtask

  // Driver: present the next pending item once the current one is transferred
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      cmd_i           <= 1'b0;
      opcode_i        <= '0;
      latency_value_i <= '0;
      src1_reg_i      <= '0;
      src2_reg_i      <= '0;
      dst_reg_i       <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        trace_dataflow(held_item);
        accepted_items++;
      end
      if (trace_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
        held_item = trace_items.pop_front();
        in_valid_i      <= 1'b1;
        cmd_i           <= held_item.cmd;
        opcode_i        <= held_item.opcode;
        latency_value_i <= held_item.latency;
        src1_reg_i      <= held_item.src1;
        src2_reg_i      <= held_item.src2;
        dst_reg_i       <= held_item.dst;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: compare each transferred report with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_reports.size() == 0) begin
          $error("unexpected report with inst_index 0x%0h", inst_index_o);
          mismatches++;
        end else begin
          got_report = due_reports.pop_front();
          check_field("inst_index", 32'(got_report.inst_index), 32'(inst_index_o));
          check_field("dep1_index", 32'(unsigned'(got_report.dep1)),
                      32'(unsigned'(dep1_index_o)));
          check_field("dep2_index", 32'(unsigned'(got_report.dep2)),
                      32'(unsigned'(dep2_index_o)));
          check_field("start_depth", 32'(got_report.start_depth), 32'(start_depth_o));
          check_field("program_depth", 32'(got_report.program_depth),
                      32'(program_depth_o));
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct());
    end
  end

  // Count cycles without any transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    for (int i = 0; i < NumOpcodes; i++) lat_tbl[i] = '0;
    for (int r = 0; r < NumRegs; r++) begin
      reg_writer[r] = EntryIdx;
      reg_finish[r] = '0;
    end
    inst_count = '0;
    peak_depth = '0;

    // Directed: table empty, same register read and written, extreme latencies
    queue_inst(4'd0, 5'd0, 5'd0, 5'd0);
    queue_inst(4'd15, 5'd31, 5'd31, 5'd31);
    queue_load(4'd15, 8'd255);
    queue_load(4'd0, 8'd1);
    queue_load(4'd5, 8'hAA);
    queue_load(4'd10, 8'h55);
    queue_inst(4'd15, 5'd31, 5'd0, 5'd31);
    queue_inst(4'd15, 5'd31, 5'd31, 5'd31);
    queue_inst(4'd0, 5'd31, 5'd30, 5'd1);
    queue_inst(4'd5, 5'd1, 5'd31, 5'd2);
    queue_inst(4'd10, 5'd2, 5'd2, 5'd2);
    queue_inst(4'd0, 5'd0, 5'd2, 5'd0);
    queue_load(4'd15, 8'd0);
    queue_inst(4'd15, 5'd2, 5'd1, 5'd3);
    queue_inst(4'd3, 5'd3, 5'd3, 5'd4);
    queue_inst(4'd15, 5'd4, 5'd5, 5'd4);
    queue_load(4'd0, 8'd255);
    queue_inst(4'd0, 5'd4, 5'd31, 5'd16);

    // Random: mostly instructions over hot registers, with table reloads
    for (int n = 0; n < RandomItems; n++) begin
      if ($urandom_range(0, 99) < 15)
        queue_load(OpcodeW'($urandom_range(0, NumOpcodes - 1)), pick_latency());
      else
        queue_inst(OpcodeW'($urandom_range(0, NumOpcodes - 1)), pick_reg(), pick_reg(),
                   pick_reg());
    end
    phase1_end = trace_items.size() * 2 / 5;
    phase2_end = trace_items.size() * 4 / 5;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((trace_items.size() != 0 || in_valid_i || due_reports.size() != 0) &&
           idle_cycles < StallLimit)
      @(posedge clk_i);

    if (idle_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      // let any stray report surface before the verdict
      repeat (TailCycles) @(posedge clk_i);
      @(negedge clk_i);
      if (mismatches == 0 && due_reports.size() == 0)
        $display("SUCCESS");
      else
        $display("FAILURE");
      $finish;
    end
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ddt_pkg.sv
rtl/ddt_lat_table.sv
rtl/ddt_dep_table.sv
rtl/dataflow_depth_tracker.sv
rtl/ddt_checker.sv
tb/tb_dataflow_depth_tracker.sv
